>>> sv/kve_pkg.sv
`default_nettype none
package kve_pkg;

    localparam int MAX_KEYS_DEF   = 16;
    localparam int FRAME_BITS_DEF = 24;
    localparam int VOL_W          = 16;

    localparam logic [VOL_W-1:0] DEFAULT_VOLUME_RST = 16'h8000;

    // item kinds
    localparam logic [1:0] KIND_INSERT = 2'd0;
    localparam logic [1:0] KIND_REMOVE = 2'd1;
    localparam logic [1:0] KIND_QUERY  = 2'd2;

    // result status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_FULL      = 2'd1;
    localparam logic [1:0] ST_BAD_INDEX = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_INS_WR,
        S_REM_RD,
        S_REM_WR,
        S_MUL,
        S_DIV_GO,
        S_DIV,
        S_DONE
    } state_t;

endpackage
`default_nettype wire

>>> sv/kve_cmd_if.sv
`default_nettype none
interface kve_cmd_if #(
    parameter int FRAME_W = kve_pkg::FRAME_BITS_DEF,
    parameter int IDX_W   = $clog2(kve_pkg::MAX_KEYS_DEF)
) ();
    logic               valid;
    logic               ready;
    logic [1:0]         kind;
    logic [FRAME_W-1:0] key_frame;
    logic [15:0]        key_volume;
    logic [IDX_W-1:0]   entry_index;

    modport source (output valid, kind, key_frame, key_volume, entry_index, input ready);
    modport sink   (input valid, kind, key_frame, key_volume, entry_index, output ready);
endinterface
`default_nettype wire

>>> sv/kve_rsp_if.sv
`default_nettype none
interface kve_rsp_if #(
    parameter int CNT_W = $clog2(kve_pkg::MAX_KEYS_DEF + 1)
) ();
    logic             valid;
    logic             ready;
    logic [15:0]      volume_out;
    logic [CNT_W-1:0] entry_count;
    logic [1:0]       status;

    modport source (output valid, volume_out, entry_count, status, input ready);
    modport sink   (input valid, volume_out, entry_count, status, output ready);
endinterface
`default_nettype wire

>>> sv/kve_div.sv
`default_nettype none
// Restoring divider, one numerator bit per cycle. Quotient is known to fit QW bits.
module kve_div #(
    parameter int NW = 40,
    parameter int DW = 24,
    parameter int QW = 16
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    input  wire logic [NW-1:0] num,
    input  wire logic [DW-1:0] den,
    output logic               done,
    output logic [QW-1:0]      quot
);
    localparam int SW = $clog2(NW + 1);

    logic [NW-1:0] num_reg,  num_next;
    logic [DW-1:0] den_reg,  den_next;
    logic [DW:0]   rem_reg,  rem_next;
    logic [QW-1:0] quot_reg, quot_next;
    logic [SW-1:0] step_reg, step_next;
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [DW:0]   trial;

    // load operands on start, else one shift-subtract step while busy
    always_comb
    begin
        num_next  = num_reg;
        den_next  = den_reg;
        rem_next  = rem_reg;
        quot_next = quot_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg[DW-1:0], num_reg[NW-1]};
        if (start)
        begin
            num_next  = num;
            den_next  = den;
            rem_next  = '0;
            quot_next = '0;
            step_next = SW'(NW);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            num_next = {num_reg[NW-2:0], 1'b0};
            if (trial >= {1'b0, den_reg})
            begin
                rem_next  = trial - {1'b0, den_reg};
                quot_next = {quot_reg[QW-2:0], 1'b1};
            end
            else
            begin
                rem_next  = trial;
                quot_next = {quot_reg[QW-2:0], 1'b0};
            end
            step_next = step_reg - 1'b1;
            if (step_reg == SW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg  <= num_next;
        den_reg  <= den_next;
        rem_reg  <= rem_next;
        quot_reg <= quot_next;
    end

    assign done = done_reg;
    assign quot = quot_reg;

endmodule
`default_nettype wire

>>> sv/keyframe_volume_envelope.sv
// Keyframe volume envelope: sorted keyframe table in one synchronous RAM.
// Items are taken one at a time. Inserts and queries scan the table entry by entry;
// an insert shifts later entries up and a remove shifts later entries down, one entry
// at a time; a query that interpolates multiplies and then waits for the serial divider.
// Reset empties the table (count zero) and sets default volume to 0x8000.
`default_nettype none
module keyframe_volume_envelope #(
    parameter int MAX_KEYS   = kve_pkg::MAX_KEYS_DEF,
    parameter int FRAME_BITS = kve_pkg::FRAME_BITS_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [15:0] cfg_wdata,
    kve_cmd_if.sink          cmd,
    kve_rsp_if.source        rsp
);
    localparam int AW = $clog2(MAX_KEYS);
    localparam int CW = $clog2(MAX_KEYS + 1);
    localparam int VW = kve_pkg::VOL_W;
    localparam int EW = FRAME_BITS + VW;
    localparam int NW = VW + FRAME_BITS;

    // entry RAM: {frame, volume}
    logic [EW-1:0] mem [MAX_KEYS];
    logic [EW-1:0] rdata_reg;
    logic          mem_we;
    logic [AW-1:0] mem_waddr, mem_raddr;
    logic [EW-1:0] mem_wdata;

    kve_pkg::state_t state_reg, state_next;

    logic [15:0]         dflt_reg;
    logic [1:0]          kind_reg,   kind_next;
    logic [FRAME_BITS-1:0] frame_reg, frame_next;
    logic [VW-1:0]       vin_reg,    vin_next;
    logic [CW-1:0]       cnt_reg,    cnt_next;
    logic [CW-1:0]       i_reg,      i_next;
    logic [CW-1:0]       j_reg,      j_next;
    logic [FRAME_BITS-1:0] pf_reg,   pf_next;
    logic [VW-1:0]       pv_reg,     pv_next;
    logic [VW-1:0]       diff_reg,   diff_next;
    logic                dneg_reg,   dneg_next;
    logic [FRAME_BITS-1:0] df_reg,   df_next;
    logic [FRAME_BITS-1:0] span_reg, span_next;
    logic [NW-1:0]       num_reg,    num_next;
    logic [1:0]          stat_reg,   stat_next;
    logic [VW-1:0]       res_reg,    res_next;

    logic                out_valid_reg;
    logic [VW-1:0]       out_vol_reg;
    logic [CW-1:0]       out_cnt_reg;
    logic [1:0]          out_st_reg;

    logic                accept, out_free, div_start, div_done;
    logic [VW-1:0]       quot;
    logic [FRAME_BITS-1:0] rd_frame;
    logic [VW-1:0]       rd_vol;

    assign rd_frame  = rdata_reg[EW-1:VW];
    assign rd_vol    = rdata_reg[VW-1:0];
    assign cmd.ready = (state_reg == kve_pkg::S_IDLE);
    assign accept    = cmd.valid && cmd.ready;
    assign out_free  = !out_valid_reg || rsp.ready;

    // RAM, one write and one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rdata_reg <= mem[mem_raddr];
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            kve_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    case (cmd.kind)
                        kve_pkg::KIND_INSERT, kve_pkg::KIND_QUERY:
                            state_next = kve_pkg::S_SCAN_RD;
                        kve_pkg::KIND_REMOVE:
                            state_next = ({{(CW-AW){1'b0}}, cmd.entry_index} >= cnt_reg)
                                         ? kve_pkg::S_DONE : kve_pkg::S_REM_RD;
                        default:
                            state_next = kve_pkg::S_DONE;
                    endcase
                end
            end
            kve_pkg::S_SCAN_RD:
            begin
                if (i_reg == cnt_reg)
                begin
                    if (kind_reg == kve_pkg::KIND_INSERT && cnt_reg != CW'(MAX_KEYS))
                        state_next = kve_pkg::S_INS_WR;
                    else
                        state_next = kve_pkg::S_DONE;
                end
                else
                    state_next = kve_pkg::S_SCAN_CHK;
            end
            kve_pkg::S_SCAN_CHK:
            begin
                if (rd_frame >= frame_reg)
                begin
                    if (kind_reg == kve_pkg::KIND_INSERT)
                    begin
                        if (rd_frame == frame_reg || cnt_reg == CW'(MAX_KEYS))
                            state_next = kve_pkg::S_DONE;
                        else
                            state_next = kve_pkg::S_SHIFT_RD;
                    end
                    else if (i_reg == '0 || rd_frame == frame_reg)
                        state_next = kve_pkg::S_DONE;
                    else
                        state_next = kve_pkg::S_MUL;
                end
                else
                    state_next = kve_pkg::S_SCAN_RD;
            end
            kve_pkg::S_SHIFT_RD:
                state_next = (j_reg == i_reg) ? kve_pkg::S_INS_WR : kve_pkg::S_SHIFT_WR;
            kve_pkg::S_SHIFT_WR: state_next = kve_pkg::S_SHIFT_RD;
            kve_pkg::S_INS_WR:   state_next = kve_pkg::S_DONE;
            kve_pkg::S_REM_RD:
                state_next = (j_reg == cnt_reg) ? kve_pkg::S_DONE : kve_pkg::S_REM_WR;
            kve_pkg::S_REM_WR:   state_next = kve_pkg::S_REM_RD;
            kve_pkg::S_MUL:      state_next = kve_pkg::S_DIV_GO;
            kve_pkg::S_DIV_GO:   state_next = kve_pkg::S_DIV;
            kve_pkg::S_DIV:
                if (div_done)
                    state_next = kve_pkg::S_DONE;
            kve_pkg::S_DONE:
                if (out_free)
                    state_next = kve_pkg::S_IDLE;
            default: state_next = kve_pkg::S_IDLE;
        endcase
    end

    // datapath and RAM control
    always_comb
    begin
        kind_next  = kind_reg;
        frame_next = frame_reg;
        vin_next   = vin_reg;
        cnt_next   = cnt_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        pf_next    = pf_reg;
        pv_next    = pv_reg;
        diff_next  = diff_reg;
        dneg_next  = dneg_reg;
        df_next    = df_reg;
        span_next  = span_reg;
        num_next   = num_reg;
        stat_next  = stat_reg;
        res_next   = res_reg;
        mem_we     = 1'b0;
        mem_waddr  = i_reg[AW-1:0];
        mem_wdata  = rdata_reg;
        mem_raddr  = i_reg[AW-1:0];
        div_start  = 1'b0;
        case (state_reg)
            kve_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    kind_next  = cmd.kind;
                    frame_next = cmd.key_frame;
                    vin_next   = cmd.key_volume;
                    i_next     = '0;
                    j_next     = {{(CW-AW){1'b0}}, cmd.entry_index} + 1'b1;
                    res_next   = '0;
                    stat_next  = kve_pkg::ST_OK;
                    if (cmd.kind == kve_pkg::KIND_REMOVE &&
                        {{(CW-AW){1'b0}}, cmd.entry_index} >= cnt_reg)
                        stat_next = kve_pkg::ST_BAD_INDEX;
                end
            end
            kve_pkg::S_SCAN_RD:
            begin
                // end of table: insert appends unless full, query holds last volume (default if empty)
                if (i_reg == cnt_reg)
                begin
                    if (kind_reg == kve_pkg::KIND_INSERT)
                    begin
                        if (cnt_reg == CW'(MAX_KEYS))
                            stat_next = kve_pkg::ST_FULL;
                    end
                    else
                        res_next = (cnt_reg == '0) ? dflt_reg : pv_reg;
                end
            end
            kve_pkg::S_SCAN_CHK:
            begin
                if (rd_frame >= frame_reg)
                begin
                    if (kind_reg == kve_pkg::KIND_INSERT)
                    begin
                        if (rd_frame == frame_reg)
                        begin
                            mem_we    = 1'b1;
                            mem_wdata = {rd_frame, vin_reg};
                        end
                        else if (cnt_reg == CW'(MAX_KEYS))
                            stat_next = kve_pkg::ST_FULL;
                        j_next = cnt_reg;
                    end
                    else
                    begin
                        res_next  = rd_vol;
                        dneg_next = rd_vol < pv_reg;
                        diff_next = (rd_vol < pv_reg) ? pv_reg - rd_vol : rd_vol - pv_reg;
                        df_next   = frame_reg - pf_reg;
                        span_next = rd_frame - pf_reg;
                    end
                end
                else
                begin
                    pf_next = rd_frame;
                    pv_next = rd_vol;
                    i_next  = i_reg + 1'b1;
                end
            end
            kve_pkg::S_SHIFT_RD:
            begin
                if (j_reg != i_reg)
                    mem_raddr = AW'(j_reg - 1'b1);
            end
            kve_pkg::S_SHIFT_WR:
            begin
                mem_we    = 1'b1;
                mem_waddr = j_reg[AW-1:0];
                j_next    = j_reg - 1'b1;
            end
            kve_pkg::S_INS_WR:
            begin
                mem_we    = 1'b1;
                mem_wdata = {frame_reg, vin_reg};
                cnt_next  = cnt_reg + 1'b1;
            end
            kve_pkg::S_REM_RD:
            begin
                if (j_reg == cnt_reg)
                    cnt_next = cnt_reg - 1'b1;
                else
                    mem_raddr = j_reg[AW-1:0];
            end
            kve_pkg::S_REM_WR:
            begin
                mem_we    = 1'b1;
                mem_waddr = AW'(j_reg - 1'b1);
                j_next    = j_reg + 1'b1;
            end
            kve_pkg::S_MUL:
                num_next = NW'({{FRAME_BITS{1'b0}}, diff_reg} * {{VW{1'b0}}, df_reg});
            kve_pkg::S_DIV_GO:
                div_start = 1'b1;
            kve_pkg::S_DIV:
            begin
                if (div_done)
                    res_next = dneg_reg ? pv_reg - quot : pv_reg + quot;
            end
            default: ;
        endcase
    end

    kve_div #(
        .NW (NW),
        .DW (FRAME_BITS),
        .QW (VW)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (num_reg),
        .den   (span_reg),
        .done  (div_done),
        .quot  (quot)
    );

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= kve_pkg::S_IDLE;
            cnt_reg       <= '0;
            dflt_reg      <= kve_pkg::DEFAULT_VOLUME_RST;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            if (cfg_we)
                dflt_reg <= cfg_wdata;
            if (state_reg == kve_pkg::S_DONE && out_free)
                out_valid_reg <= 1'b1;
            else if (rsp.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        kind_reg  <= kind_next;
        frame_reg <= frame_next;
        vin_reg   <= vin_next;
        i_reg     <= i_next;
        j_reg     <= j_next;
        pf_reg    <= pf_next;
        pv_reg    <= pv_next;
        diff_reg  <= diff_next;
        dneg_reg  <= dneg_next;
        df_reg    <= df_next;
        span_reg  <= span_next;
        num_reg   <= num_next;
        stat_reg  <= stat_next;
        res_reg   <= res_next;
        if (state_reg == kve_pkg::S_DONE && out_free)
        begin
            out_vol_reg <= res_reg;
            out_cnt_reg <= cnt_reg;
            out_st_reg  <= stat_reg;
        end
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.volume_out  = out_vol_reg;
    assign rsp.entry_count = out_cnt_reg;
    assign rsp.status      = out_st_reg;

    // checks
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CW'(MAX_KEYS))
        else $error("entry count beyond table size");

    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg != kve_pkg::S_IDLE)
        else $error("accepted item did not start work");

    a_write_in_table: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> {{(CW-AW){1'b0}}, mem_waddr} <= cnt_reg)
        else $error("RAM write past table end");

    a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> state_reg == kve_pkg::S_DIV)
        else $error("divider finished outside divide state");

endmodule
`default_nettype wire

>>> test/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NKEYS = kve_pkg::MAX_KEYS_DEF;

    // kind with no operation behind it
    localparam logic [1:0] KIND_SPARE = 2'd3;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [15:0] cfg_wdata;

    kve_cmd_if cmd ();
    kve_rsp_if rsp ();

    keyframe_volume_envelope uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd.sink),
        .rsp       (rsp.source)
    );

    typedef struct packed {
        logic [15:0] volume;
        logic [4:0]  count;
        logic [1:0]  status;
    } outcome_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [23:0] frame;
        logic [15:0] volume;
        logic [3:0]  index;
        logic        known;
        logic [15:0] exp_volume;
        logic [4:0]  exp_count;
        logic [1:0]  exp_status;
    } row_t;

    // predictor state
    logic [23:0] env_frames [NKEYS];
    logic [15:0] env_levels [NKEYS];
    int          env_count;
    logic [15:0] env_default;

    outcome_t pending_outcomes [$];
    int       fail_count;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #200ms;
        $display("Test completed with failures");
        $finish;
    end

    function automatic logic [15:0] blend(int i, logic [23:0] f);
        longint fa;
        longint fb;
        longint va;
        longint vb;
        longint q;
        fa = env_frames[i];
        fb = env_frames[i + 1];
        va = env_levels[i];
        vb = env_levels[i + 1];
        if (fb == fa)
            return va[15:0];
        if (vb >= va)
        begin
            q = ((vb - va) * (f - fa)) / (fb - fa);
            return 16'(va + q);
        end
        q = ((va - vb) * (f - fa)) / (fb - fa);
        return 16'(va - q);
    endfunction

    function automatic logic [15:0] envelope_at(logic [23:0] f);
        if (env_count == 0)
            return env_default;
        if (f <= env_frames[0])
            return env_levels[0];
        if (f >= env_frames[env_count - 1])
            return env_levels[env_count - 1];
        for (int i = 0; i + 1 < env_count; i++)
            if (f >= env_frames[i] && f <= env_frames[i + 1])
                return blend(i, f);
        return env_default;
    endfunction

    // applies one item to the shadow table, returns the expected result
    function automatic outcome_t apply_item(logic [1:0] kind, logic [23:0] f,
                                            logic [15:0] v, logic [3:0] idx);
        outcome_t o;
        int pos;
        o = '0;
        if (kind == kve_pkg::KIND_INSERT)
        begin
            pos = 0;
            while (pos < env_count && env_frames[pos] < f)
                pos++;
            if (pos < env_count && env_frames[pos] == f)
                env_levels[pos] = v;
            else if (env_count >= NKEYS)
                o.status = kve_pkg::ST_FULL;
            else
            begin
                for (int j = env_count; j > pos; j--)
                begin
                    env_frames[j] = env_frames[j - 1];
                    env_levels[j] = env_levels[j - 1];
                end
                env_frames[pos] = f;
                env_levels[pos] = v;
                env_count++;
            end
        end
        else if (kind == kve_pkg::KIND_REMOVE)
        begin
            if (idx >= env_count)
                o.status = kve_pkg::ST_BAD_INDEX;
            else
            begin
                for (int j = idx; j + 1 < env_count; j++)
                begin
                    env_frames[j] = env_frames[j + 1];
                    env_levels[j] = env_levels[j + 1];
                end
                env_count--;
            end
        end
        else if (kind == kve_pkg::KIND_QUERY)
            o.volume = envelope_at(f);
        o.count = 5'(env_count);
        return o;
    endfunction

    task automatic send_item(logic [1:0] kind, logic [23:0] f, logic [15:0] v,
                             logic [3:0] idx);
        outcome_t o;
        // random gap before some items
        if ($urandom_range(0, 5) == 0)
        begin
            cmd.valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
        cmd.valid       <= 1'b1;
        cmd.kind        <= kind;
        cmd.key_frame   <= f;
        cmd.key_volume  <= v;
        cmd.entry_index <= idx;
        @(posedge clk);
        while (!cmd.ready)
            @(posedge clk);
        o = apply_item(kind, f, v, idx);
        pending_outcomes = {pending_outcomes, o};
    endtask

    task automatic drain_and_idle();
        cmd.valid <= 1'b0;
        @(posedge clk);
        while (pending_outcomes.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
    endtask

    task automatic write_default(logic [15:0] value);
        drain_and_idle();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        env_default = value;
    endtask

    // response checker
    always @(posedge clk)
    begin
        if (rst_n && rsp.valid && rsp.ready)
        begin
            if (pending_outcomes.size() == 0)
            begin
                $display("%0t: unexpected result %h/%0d/%0d", $time, rsp.volume_out,
                         rsp.entry_count, rsp.status);
                fail_count++;
            end
            else
            begin
                outcome_t e;
                e = pending_outcomes.pop_front();
                if (rsp.volume_out !== e.volume)
                begin
                    $display("%0t: volume expected %h actual %h", $time, e.volume,
                             rsp.volume_out);
                    fail_count++;
                end
                if (rsp.entry_count !== e.count)
                begin
                    $display("%0t: count expected %0d actual %0d", $time, e.count,
                             rsp.entry_count);
                    fail_count++;
                end
                if (rsp.status !== e.status)
                begin
                    $display("%0t: status expected %0d actual %0d", $time, e.status,
                             rsp.status);
                    fail_count++;
                end
            end
        end
    end

    // receiver stall pattern: phases of always-ready and of random stalls
    initial
    begin
        int phase;
        rsp.ready <= 1'b0;
        phase = 0;
        forever
        begin
            @(posedge clk);
            phase++;
            if ((phase / 300) % 3 == 0)
                rsp.ready <= 1'b1;
            else
                rsp.ready <= ($urandom_range(0, 3) != 0);
        end
    end

    row_t directed [18] = '{
        // kind, frame, volume, index, known, exp vol, exp count, exp status
        '{kve_pkg::KIND_QUERY,  24'd0,      16'd0,    4'd0,  1'b1, 16'h8000, 5'd0,
          kve_pkg::ST_OK},
        '{kve_pkg::KIND_REMOVE, 24'd0,      16'd0,    4'd0,  1'b1, 16'h0000, 5'd0,
          kve_pkg::ST_BAD_INDEX},
        '{kve_pkg::KIND_INSERT, 24'd100,    16'h0000, 4'd0,  1'b1, 16'h0000, 5'd1,
          kve_pkg::ST_OK},
        '{kve_pkg::KIND_QUERY,  24'd0,      16'd0,    4'd0,  1'b1, 16'h0000, 5'd1,
          kve_pkg::ST_OK},
        '{kve_pkg::KIND_INSERT, 24'hFFFFFF, 16'hFFFF, 4'd0,  1'b1, 16'h0000, 5'd2,
          kve_pkg::ST_OK},
        '{kve_pkg::KIND_QUERY,  24'hFFFFFF, 16'd0,    4'd0,  1'b1, 16'hFFFF, 5'd2,
          kve_pkg::ST_OK},
        '{kve_pkg::KIND_QUERY,  24'h800000, 16'd0,    4'd0,  1'b0, 16'h0,    5'd0,
          kve_pkg::ST_OK},
        '{kve_pkg::KIND_INSERT, 24'd0,      16'hFFFF, 4'd0,  1'b1, 16'h0000, 5'd3,
          kve_pkg::ST_OK},
        '{kve_pkg::KIND_QUERY,  24'd50,     16'd0,    4'd0,  1'b0, 16'h0,    5'd0,
          kve_pkg::ST_OK},
        '{kve_pkg::KIND_INSERT, 24'd100,    16'h1234, 4'd0,  1'b1, 16'h0000, 5'd3,
          kve_pkg::ST_OK},
        '{kve_pkg::KIND_QUERY,  24'd100,    16'd0,    4'd0,  1'b1, 16'h1234, 5'd3,
          kve_pkg::ST_OK},
        '{kve_pkg::KIND_QUERY,  24'h7FFFFF, 16'd0,    4'd0,  1'b0, 16'h0,    5'd0,
          kve_pkg::ST_OK},
        '{KIND_SPARE,           24'hABCDEF, 16'hAAAA, 4'd5,  1'b1, 16'h0000, 5'd3,
          kve_pkg::ST_OK},
        '{kve_pkg::KIND_REMOVE, 24'd0,      16'd0,    4'd15, 1'b1, 16'h0000, 5'd3,
          kve_pkg::ST_BAD_INDEX},
        '{kve_pkg::KIND_REMOVE, 24'd0,      16'd0,    4'd2,  1'b1, 16'h0000, 5'd2,
          kve_pkg::ST_OK},
        '{kve_pkg::KIND_QUERY,  24'hFFFFFF, 16'd0,    4'd0,  1'b1, 16'h1234, 5'd2,
          kve_pkg::ST_OK},
        '{kve_pkg::KIND_REMOVE, 24'd0,      16'd0,    4'd0,  1'b1, 16'h0000, 5'd1,
          kve_pkg::ST_OK},
        '{kve_pkg::KIND_REMOVE, 24'd0,      16'd0,    4'd0,  1'b1, 16'h0000, 5'd0,
          kve_pkg::ST_OK}
    };

    // fill the table, hit full, replace while full, remove the last entry, query across it
    task automatic fill_and_probe();
        for (int i = 0; i < NKEYS; i++)
            send_item(kve_pkg::KIND_INSERT, 24'(i * 1000 + $urandom_range(0, 999)),
                      16'($urandom), 4'(0));
        send_item(kve_pkg::KIND_INSERT, 24'hFFFFF0, 16'h5555, 4'd0);
        send_item(kve_pkg::KIND_INSERT, env_frames[7], 16'hAAAA, 4'd0);
        send_item(kve_pkg::KIND_REMOVE, 24'd0, 16'd0, 4'd15);
        for (int i = 0; i < 10; i++)
            send_item(kve_pkg::KIND_QUERY, 24'($urandom_range(0, 17000)), 16'd0, 4'd0);
    endtask

    initial
    begin
        logic [23:0] lo;
        logic [23:0] span;
        int r;
        outcome_t got;
        cfg_we          = 1'b0;
        cfg_wdata       = '0;
        cmd.valid       = 1'b0;
        cmd.kind        = kve_pkg::KIND_INSERT;
        cmd.key_frame   = '0;
        cmd.key_volume  = '0;
        cmd.entry_index = '0;
        fail_count      = 0;
        env_count       = 0;
        env_default     = kve_pkg::DEFAULT_VOLUME_RST;
        rst_n           = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed rows; known rows are compared against typed values too
        foreach (directed[i])
        begin
            send_item(directed[i].kind, directed[i].frame, directed[i].volume,
                      directed[i].index);
            got = pending_outcomes[pending_outcomes.size() - 1];
            if (directed[i].known &&
                got !== {directed[i].exp_volume, directed[i].exp_count,
                         directed[i].exp_status})
            begin
                $display("%0t: row %0d expected %h/%0d/%0d predicted %h/%0d/%0d", $time,
                         i, directed[i].exp_volume, directed[i].exp_count,
                         directed[i].exp_status, got.volume, got.count, got.status);
                fail_count++;
            end
        end

        // default volume extremes on an empty table
        write_default(16'h0000);
        send_item(kve_pkg::KIND_QUERY, 24'd5, 16'd0, 4'd0);
        write_default(16'hFFFF);
        send_item(kve_pkg::KIND_QUERY, 24'd5, 16'd0, 4'd0);
        fill_and_probe();

        // random phase, several default settings
        for (int p = 0; p < 4; p++)
        begin
            write_default(16'($urandom));
            lo   = 24'($urandom);
            span = (p % 2) ? 24'($urandom) : 24'($urandom_range(16, 4000));
            for (int n = 0; n < 260; n++)
            begin
                r = $urandom_range(0, 99);
                if (r < 35)
                    send_item(kve_pkg::KIND_INSERT,
                              (r < 3) ? 24'($urandom) : 24'(lo + $urandom_range(0, span)),
                              16'($urandom), 4'($urandom));
                else if (r < 55)
                    send_item(kve_pkg::KIND_REMOVE, 24'($urandom), 16'($urandom),
                              4'($urandom_range(0, (env_count > 0) ? env_count + 1 : 15)));
                else if (r < 98)
                    send_item(kve_pkg::KIND_QUERY,
                              (r < 60) ? 24'($urandom) :
                              24'(lo + $urandom_range(0, span)),
                              16'($urandom), 4'($urandom));
                else
                    send_item(KIND_SPARE, 24'($urandom), 16'($urandom), 4'($urandom));
            end
        end
        write_default(kve_pkg::DEFAULT_VOLUME_RST);
        fill_and_probe();

        drain_and_idle();
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule
